### hw/rtl/thermistor_average_to_celsius_core_assert.svh
// Assertion macros of the thermistor averaging RTL, used by tac_ctrl.
// Define NO_ASSERTIONS to compile them away.
`ifndef THERMISTOR_AVERAGE_TO_CELSIUS_CORE_ASSERT_SVH
`define THERMISTOR_AVERAGE_TO_CELSIUS_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TAC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tac assertion failed");
`define TAC_ASSERT_NEXT(label, clk, rst, cause, effect) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error("tac assertion failed");
`else
`define TAC_ASSERT(label, clk, rst, prop)
`define TAC_ASSERT_NEXT(label, clk, rst, cause, effect)
`endif
`endif

### hw/rtl/tac_pkg.sv
// Shared types and constants of the thermistor averaging core.
// Used by tac_ctrl, tac_datapath and the top level; depends on nothing.
package tac_pkg;

   localparam int MAX_AVERAGE_DEFAULT = 256;
   localparam int ADC_BITS_DEFAULT    = 10;
   localparam int SAMPLE_WIDTH        = 10;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH      = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SERIES_RESISTANCE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEFF_A           = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEFF_B           = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEFF_C           = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AVERAGE_COUNT     = 3'd4;

   localparam logic [19:0]        RESET_SERIES_RESISTANCE = 20'd10000;
   localparam logic [30:0]        RESET_COEFF_A           = 31'd1109680000;
   localparam logic signed [31:0] RESET_COEFF_B           = 32'sd261508000;
   localparam logic signed [31:0] RESET_COEFF_C           = 32'sd909370000;
   localparam logic [8:0]         RESET_AVERAGE_COUNT     = 9'd8;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_MEAN_ZERO = 2'd1;
   localparam logic [1:0] STATUS_MEAN_FULL = 2'd2;

   // ln(2) in Q30
   localparam logic signed [31:0] LN2_Q30     = 32'sd744261118;
   localparam logic signed [16:0] TEMP_MIN    = -17'sd27315;
   localparam logic signed [16:0] TEMP_MAX    = 17'sd65535;
   localparam logic [16:0]        OFFSET_CENTI = 17'd27315;
   localparam logic [63:0]        CK_LIMIT    = 64'd92850;
   localparam logic [63:0]        CK_NUMER    = 64'd100 << 57;

   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_START,
      CMD_ADD,
      CMD_DIV_MEAN,
      CMD_DIV_STEP,
      CMD_MEAN,
      CMD_MUL_X,
      CMD_NORM,
      CMD_MANT,
      CMD_SQ,
      CMD_SAVE_LX,
      CMD_LN_MUL,
      CMD_LN_SHIFT,
      CMD_L2_MUL,
      CMD_L2_SHIFT,
      CMD_L3_HI,
      CMD_L3_LO,
      CMD_L3_SHIFT,
      CMD_SB,
      CMD_SC,
      CMD_SSUM,
      CMD_DIV_TEMP,
      CMD_TEMP_RESULT,
      CMD_ERR_RESULT
   } cmd_type;

   typedef struct packed {
      logic cnt_reached;
      logic mean_zero;
      logic mean_full;
      logic norm_top;
      logic s_neg;
      logic d_zero;
   } dp_status_type;

   typedef struct packed {
      logic [19:0]        series_resistance;
      logic [30:0]        coeff_a;
      logic signed [31:0] coeff_b;
      logic signed [31:0] coeff_c;
      logic [8:0]         average_count;
   } cfg_type;

endpackage

### hw/rtl/tac_datapath.sv
// Datapath of the thermistor averaging core: accumulator, shift-subtract divider,
// log2 unit and the Steinhart-Hart arithmetic. Executes one command per cycle.
// Depends on tac_pkg.
module tac_datapath #(
   parameter int MAX_AVERAGE = tac_pkg::MAX_AVERAGE_DEFAULT,
   parameter int ADC_BITS    = tac_pkg::ADC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  tac_pkg::cmd_type                    cmd,
   input  tac_pkg::cfg_type                    cfg,
   input  logic [tac_pkg::SAMPLE_WIDTH-1:0]    sample,
   output tac_pkg::dp_status_type              status,
   output logic signed [16:0]                  temperature,
   output logic [1:0]                          result_status
);

   localparam int CW = $clog2(MAX_AVERAGE + 1);
   localparam int SW = ADC_BITS + CW;
   localparam int EW = ((CW > 9) ? CW : 9) + 1;
   localparam int XW = 20 + ADC_BITS;
   localparam int NW = (XW > 31) ? XW : 31;
   localparam int EB = $clog2(NW);
   localparam int LB = EB + 24;

   logic [SW-1:0]          sum_ff;
   logic [CW-1:0]          cnt_ff;
   logic [63:0]            dq_ff;
   logic [64:0]            drem_ff;
   logic [63:0]            dden_ff;
   logic [ADC_BITS-1:0]    mean_ff;
   logic [NW-1:0]          norm_ff;
   logic [EB-1:0]          e_ff;
   logic [30:0]            m_ff;
   logic [23:0]            frac_ff;
   logic [LB-1:0]          lx_ff;
   logic signed [63:0]     prod_ff;
   logic signed [31:0]     lnr_ff;
   logic [35:0]            l2_ff;
   logic signed [31:0]     l3s_ff;
   logic signed [67:0]     acc_ff;
   logic signed [67:0]     s_ff;
   logic signed [16:0]     temp_ff;
   logic [1:0]             rstat_ff;

   logic [ADC_BITS+9:0]    sample_ext;
   logic [ADC_BITS-1:0]    samp;
   logic [EW-1:0]          eff_count;
   logic [19:0]            r1;
   logic [XW-1:0]          xprod;
   logic [64:0]            dtrial;
   logic                   dge;
   logic [61:0]            sq_p;
   logic [31:0]            sq_t;
   logic [LB-1:0]          log_val;
   logic signed [LB:0]     ln_diff;
   logic signed [LB+32:0]  ln_p;
   logic signed [63:0]     l2_p;
   logic signed [50:0]     hi_p;
   logic signed [50:0]     lo_p;
   logic signed [63:0]     b_p;
   logic signed [63:0]     c_p;
   logic signed [67:0]     l3_sum;
   logic [59:0]            d_val;

   assign sample_ext = {{ADC_BITS{1'b0}}, sample};
   assign samp       = sample_ext[ADC_BITS-1:0];

   always_comb begin
      if (cfg.average_count == 9'd0) begin
         eff_count = EW'(1);
      end else if (EW'(cfg.average_count) > EW'(MAX_AVERAGE)) begin
         eff_count = EW'(MAX_AVERAGE);
      end else begin
         eff_count = EW'(cfg.average_count);
      end
   end

   assign r1      = (cfg.series_resistance == 20'd0) ? 20'd1 : cfg.series_resistance;
   assign xprod   = r1 * ({ADC_BITS{1'b1}} - mean_ff);
   assign dtrial  = {drem_ff[63:0], dq_ff[63]};
   assign dge     = dtrial >= {1'b0, dden_ff};
   assign sq_p    = m_ff * m_ff;
   assign sq_t    = sq_p[61:30];
   assign log_val = {e_ff, frac_ff};
   assign ln_diff = $signed({1'b0, lx_ff}) - $signed({1'b0, log_val});
   assign ln_p    = ln_diff * tac_pkg::LN2_Q30;
   assign l2_p    = lnr_ff * lnr_ff;
   assign hi_p    = lnr_ff * $signed({1'b0, l2_ff[35:18]});
   assign lo_p    = lnr_ff * $signed({1'b0, l2_ff[17:0]});
   assign b_p     = cfg.coeff_b * lnr_ff;
   assign c_p     = cfg.coeff_c * l3s_ff;
   assign l3_sum  = acc_ff + 68'(prod_ff);
   assign d_val   = s_ff[66:7];

   always_ff @(posedge clock) begin
      case (cmd)
         tac_pkg::CMD_START: begin
            sum_ff <= SW'(samp);
            cnt_ff <= CW'(1);
         end
         tac_pkg::CMD_ADD: begin
            sum_ff <= sum_ff + SW'(samp);
            cnt_ff <= cnt_ff + CW'(1);
         end
         tac_pkg::CMD_DIV_MEAN: begin
            dq_ff   <= 64'(sum_ff);
            dden_ff <= 64'(cnt_ff);
            drem_ff <= '0;
         end
         tac_pkg::CMD_DIV_STEP: begin
            drem_ff <= dge ? (dtrial - {1'b0, dden_ff}) : dtrial;
            dq_ff   <= {dq_ff[62:0], dge};
         end
         tac_pkg::CMD_MEAN: begin
            mean_ff <= dq_ff[ADC_BITS-1:0];
         end
         tac_pkg::CMD_MUL_X: begin
            norm_ff <= NW'(xprod);
            e_ff    <= EB'(NW - 1);
         end
         tac_pkg::CMD_NORM: begin
            if (!norm_ff[NW-1]) begin
               norm_ff <= {norm_ff[NW-2:0], 1'b0};
               e_ff    <= e_ff - EB'(1);
            end
         end
         tac_pkg::CMD_MANT: begin
            m_ff    <= norm_ff[NW-1 -: 31];
            frac_ff <= '0;
         end
         tac_pkg::CMD_SQ: begin
            // halve and emit a one when the square reaches two
            if (sq_t[31]) begin
               m_ff    <= sq_t[31:1];
               frac_ff <= {frac_ff[22:0], 1'b1};
            end else begin
               m_ff    <= sq_t[30:0];
               frac_ff <= {frac_ff[22:0], 1'b0};
            end
         end
         tac_pkg::CMD_SAVE_LX: begin
            lx_ff   <= log_val;
            norm_ff <= NW'(mean_ff);
            e_ff    <= EB'(NW - 1);
         end
         tac_pkg::CMD_LN_MUL: begin
            prod_ff <= 64'(ln_p);
         end
         tac_pkg::CMD_LN_SHIFT: begin
            lnr_ff <= 32'(prod_ff >>> 30);
         end
         tac_pkg::CMD_L2_MUL: begin
            prod_ff <= l2_p;
         end
         tac_pkg::CMD_L2_SHIFT: begin
            l2_ff <= prod_ff[59:24];
         end
         tac_pkg::CMD_L3_HI: begin
            prod_ff <= 64'(hi_p);
         end
         tac_pkg::CMD_L3_LO: begin
            acc_ff  <= 68'(prod_ff) <<< 18;
            prod_ff <= 64'(lo_p);
         end
         tac_pkg::CMD_L3_SHIFT: begin
            // both floor shifts of the cube at once
            l3s_ff <= 32'(l3_sum >>> 36);
         end
         tac_pkg::CMD_SB: begin
            prod_ff <= b_p;
         end
         tac_pkg::CMD_SC: begin
            acc_ff  <= $signed({13'd0, cfg.coeff_a, 24'd0}) + 68'(prod_ff);
            prod_ff <= c_p;
         end
         tac_pkg::CMD_SSUM: begin
            s_ff <= acc_ff + 68'(prod_ff);
         end
         tac_pkg::CMD_DIV_TEMP: begin
            dq_ff   <= tac_pkg::CK_NUMER + 64'(d_val[59:1]);
            dden_ff <= 64'(d_val);
            drem_ff <= '0;
         end
         tac_pkg::CMD_TEMP_RESULT: begin
            rstat_ff <= tac_pkg::STATUS_OK;
            if (s_ff[67]) begin
               temp_ff <= tac_pkg::TEMP_MIN;
            end else if (d_val == 60'd0 || dq_ff > tac_pkg::CK_LIMIT) begin
               temp_ff <= tac_pkg::TEMP_MAX;
            end else begin
               temp_ff <= $signed(dq_ff[16:0] - tac_pkg::OFFSET_CENTI);
            end
         end
         tac_pkg::CMD_ERR_RESULT: begin
            temp_ff  <= '0;
            rstat_ff <= (mean_ff == '0) ? tac_pkg::STATUS_MEAN_ZERO
                                         : tac_pkg::STATUS_MEAN_FULL;
         end
         default: begin
         end
      endcase
   end

   assign status.cnt_reached = EW'(cnt_ff) >= eff_count;
   assign status.mean_zero   = mean_ff == '0;
   assign status.mean_full   = mean_ff == {ADC_BITS{1'b1}};
   assign status.norm_top    = norm_ff[NW-1];
   assign status.s_neg       = s_ff[67];
   assign status.d_zero      = d_val == 60'd0;

   assign temperature   = temp_ff;
   assign result_status = rstat_ff;

endmodule

### hw/rtl/tac_ctrl.sv
// Sequencer of the thermistor averaging core: takes items, runs the
// measurement finish sequence over the datapath and holds the result handshake.
// Depends on tac_pkg and the assertion macro header.
`include "thermistor_average_to_celsius_core_assert.svh"
module tac_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_command,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  tac_pkg::dp_status_type status,
   output tac_pkg::cmd_type       cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_DIVM_RUN, S_MEAN, S_MEAN_CHK,
      S_NORM1, S_MANT1, S_SQ1, S_SAVE, S_NORM2, S_MANT2, S_SQ2,
      S_LNM, S_LNS, S_L2M, S_L2S, S_L3H, S_L3L, S_L3S,
      S_SB, S_SC, S_SSUM, S_SCHK, S_DIVT_RUN, S_TEMP, S_ERR
   } state_type;

   state_type  state_ff;
   logic [6:0] step_ff;
   logic       measuring_ff;
   logic       rsp_valid_ff;
   logic       req_take;
   logic       rsp_take;

   assign req_stall = state_ff != S_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   always_comb begin
      case (state_ff)
         S_IDLE: begin
            if (!req_take) begin
               cmd = tac_pkg::CMD_NOP;
            end else if (!req_command) begin
               cmd = tac_pkg::CMD_START;
            end else if (measuring_ff) begin
               cmd = tac_pkg::CMD_ADD;
            end else begin
               cmd = tac_pkg::CMD_NOP;
            end
         end
         S_CHECK:    cmd = tac_pkg::CMD_DIV_MEAN;
         S_DIVM_RUN: cmd = tac_pkg::CMD_DIV_STEP;
         S_MEAN:     cmd = tac_pkg::CMD_MEAN;
         S_MEAN_CHK: cmd = tac_pkg::CMD_MUL_X;
         S_NORM1:    cmd = tac_pkg::CMD_NORM;
         S_MANT1:    cmd = tac_pkg::CMD_MANT;
         S_SQ1:      cmd = tac_pkg::CMD_SQ;
         S_SAVE:     cmd = tac_pkg::CMD_SAVE_LX;
         S_NORM2:    cmd = tac_pkg::CMD_NORM;
         S_MANT2:    cmd = tac_pkg::CMD_MANT;
         S_SQ2:      cmd = tac_pkg::CMD_SQ;
         S_LNM:      cmd = tac_pkg::CMD_LN_MUL;
         S_LNS:      cmd = tac_pkg::CMD_LN_SHIFT;
         S_L2M:      cmd = tac_pkg::CMD_L2_MUL;
         S_L2S:      cmd = tac_pkg::CMD_L2_SHIFT;
         S_L3H:      cmd = tac_pkg::CMD_L3_HI;
         S_L3L:      cmd = tac_pkg::CMD_L3_LO;
         S_L3S:      cmd = tac_pkg::CMD_L3_SHIFT;
         S_SB:       cmd = tac_pkg::CMD_SB;
         S_SC:       cmd = tac_pkg::CMD_SC;
         S_SSUM:     cmd = tac_pkg::CMD_SSUM;
         S_SCHK:     cmd = tac_pkg::CMD_DIV_TEMP;
         S_DIVT_RUN: cmd = tac_pkg::CMD_DIV_STEP;
         S_TEMP:     cmd = rsp_valid_ff ? tac_pkg::CMD_NOP : tac_pkg::CMD_TEMP_RESULT;
         S_ERR:      cmd = rsp_valid_ff ? tac_pkg::CMD_NOP : tac_pkg::CMD_ERR_RESULT;
         default:    cmd = tac_pkg::CMD_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         measuring_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  if (!req_command) begin
                     measuring_ff <= 1'b1;
                     state_ff     <= S_CHECK;
                  end else if (measuring_ff) begin
                     state_ff <= S_CHECK;
                  end
               end
            end
            S_CHECK: begin
               step_ff <= '0;
               if (status.cnt_reached) begin
                  measuring_ff <= 1'b0;
                  state_ff     <= S_DIVM_RUN;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_DIVM_RUN: begin
               step_ff <= step_ff + 7'd1;
               if (step_ff == 7'd63) begin
                  state_ff <= S_MEAN;
               end
            end
            S_MEAN: state_ff <= S_MEAN_CHK;
            S_MEAN_CHK: begin
               state_ff <= (status.mean_zero || status.mean_full) ? S_ERR : S_NORM1;
            end
            S_NORM1: begin
               if (status.norm_top) begin
                  state_ff <= S_MANT1;
               end
            end
            S_MANT1: begin
               step_ff  <= '0;
               state_ff <= S_SQ1;
            end
            S_SQ1: begin
               step_ff <= step_ff + 7'd1;
               if (step_ff == 7'd23) begin
                  state_ff <= S_SAVE;
               end
            end
            S_SAVE: state_ff <= S_NORM2;
            S_NORM2: begin
               if (status.norm_top) begin
                  state_ff <= S_MANT2;
               end
            end
            S_MANT2: begin
               step_ff  <= '0;
               state_ff <= S_SQ2;
            end
            S_SQ2: begin
               step_ff <= step_ff + 7'd1;
               if (step_ff == 7'd23) begin
                  state_ff <= S_LNM;
               end
            end
            S_LNM:  state_ff <= S_LNS;
            S_LNS:  state_ff <= S_L2M;
            S_L2M:  state_ff <= S_L2S;
            S_L2S:  state_ff <= S_L3H;
            S_L3H:  state_ff <= S_L3L;
            S_L3L:  state_ff <= S_L3S;
            S_L3S:  state_ff <= S_SB;
            S_SB:   state_ff <= S_SC;
            S_SC:   state_ff <= S_SSUM;
            S_SSUM: state_ff <= S_SCHK;
            S_SCHK: begin
               step_ff  <= '0;
               state_ff <= (status.s_neg || status.d_zero) ? S_TEMP : S_DIVT_RUN;
            end
            S_DIVT_RUN: begin
               step_ff <= step_ff + 7'd1;
               if (step_ff == 7'd63) begin
                  state_ff <= S_TEMP;
               end
            end
            S_TEMP, S_ERR: begin
               // hold until the previous result is gone
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `TAC_ASSERT(a_start_only_on_take, clock, reset, (cmd == tac_pkg::CMD_START) |-> req_take)
   `TAC_ASSERT_NEXT(a_result_posted, clock, reset, (state_ff == S_TEMP && !rsp_valid_ff), (rsp_valid_ff && state_ff == S_IDLE))
   `TAC_ASSERT_NEXT(a_finish_ends_run, clock, reset, (state_ff == S_CHECK && status.cnt_reached), (!measuring_ff && state_ff == S_DIVM_RUN))

endmodule

### hw/rtl/thermistor_average_to_celsius_core.sv
// Top level of the thermistor averaging core: configuration registers,
// sequencer and datapath. Depends on tac_pkg, tac_ctrl and tac_datapath.
//
// Usage:
//   req_ channel: one item per ADC sample. req_command 0 opens a measurement
//   with this sample, 1 adds the sample to the running one (dropped when no
//   measurement runs). When the sample count reaches average_count, the mean
//   is turned into one temperature on the rsp_ channel with a status code.
//   csr_ channel: register writes by index, always ready, one per cycle.
//   Each sample item stalls the input for the count check after its take; a
//   dropped add does not. A finishing item stalls the input until its result
//   is posted: a 64-step shift-subtract divider runs twice (mean and
//   reciprocal), the log2 unit runs two normalize searches and two runs
//   of 24 squaring steps, plus 18 further steps. A negative or zero
//   denominator skips the reciprocal; an error result (mean zero or full
//   scale) skips the math and is posted straight from the mean check.
//   One result waits in an output register; sampling continues meanwhile,
//   and the next finish holds before posting until that result is taken.
//   Reset (synchronous) drops any measurement and pending result and loads
//   the default coefficients.
module thermistor_average_to_celsius_core #(
   parameter int MAX_AVERAGE = tac_pkg::MAX_AVERAGE_DEFAULT,
   parameter int ADC_BITS    = tac_pkg::ADC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_command,
   input  logic [tac_pkg::SAMPLE_WIDTH-1:0]      req_adc_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [16:0]                    rsp_temperature_centi_c,
   output logic [1:0]                            rsp_status,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tac_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [tac_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   tac_pkg::cfg_type       cfg_ff;
   tac_pkg::cmd_type       cmd;
   tac_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.series_resistance <= tac_pkg::RESET_SERIES_RESISTANCE;
         cfg_ff.coeff_a           <= tac_pkg::RESET_COEFF_A;
         cfg_ff.coeff_b           <= tac_pkg::RESET_COEFF_B;
         cfg_ff.coeff_c           <= tac_pkg::RESET_COEFF_C;
         cfg_ff.average_count     <= tac_pkg::RESET_AVERAGE_COUNT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tac_pkg::REG_SERIES_RESISTANCE: cfg_ff.series_resistance <= csr_data[19:0];
            tac_pkg::REG_COEFF_A:           cfg_ff.coeff_a           <= csr_data[30:0];
            tac_pkg::REG_COEFF_B:           cfg_ff.coeff_b           <= $signed(csr_data);
            tac_pkg::REG_COEFF_C:           cfg_ff.coeff_c           <= $signed(csr_data);
            tac_pkg::REG_AVERAGE_COUNT:     cfg_ff.average_count     <= csr_data[8:0];
            default: begin
            end
         endcase
      end
   end

   tac_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   tac_datapath #(
      .MAX_AVERAGE (MAX_AVERAGE),
      .ADC_BITS    (ADC_BITS)
   ) u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .cfg           (cfg_ff),
      .sample        (req_adc_sample),
      .status        (status),
      .temperature   (rsp_temperature_centi_c),
      .result_status (rsp_status)
   );

endmodule

### verif/thermistor_reading_checker.sv
// Checker for the thermistor averaging core: tracks register writes and accepted
// samples, predicts each temperature reading and compares it with the rsp_ channel.
// Depends on tac_pkg.
module thermistor_reading_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_command,
   input  logic [tac_pkg::SAMPLE_WIDTH-1:0]    req_adc_sample,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [16:0]                  rsp_temperature_centi_c,
   input  logic [1:0]                          rsp_status,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [tac_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tac_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int                                  mismatch_count,
   output int                                  readings_pending
);

   localparam logic [9:0] FULL_READING = 10'd1023;

   typedef struct packed {
      logic signed [16:0] temp;
      logic [1:0]         status;
   } reading_type;

   reading_type pending_readings[$];

   logic [19:0]        series_r;
   logic [30:0]        coef_a;
   logic signed [31:0] coef_b;
   logic signed [31:0] coef_c;
   logic [8:0]         avg_count;
   logic               in_measurement;
   int                 samples_taken;
   int                 reading_total;

   function automatic longint unsigned log2_fixed(input longint unsigned x);
      int top;
      longint unsigned m;
      longint unsigned frac;
      top = 0;
      frac = 0;
      for (int i = 0; i < 64; i++) if (x[i]) top = i;
      m = (top > 30) ? (x >> (top - 30)) : (x << (30 - top));
      repeat (24) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac = frac | 64'd1;
         end
      end
      return (longint'(top) << 24) | frac;
   endfunction

   function automatic reading_type mean_to_celsius(input int mean);
      reading_type res;
      longint unsigned r1;
      longint lnr, l2, l3, s, d;
      longint unsigned ck;
      res.temp = '0;
      res.status = tac_pkg::STATUS_OK;
      r1 = (series_r == 0) ? 64'd1 : longint'(series_r);
      if (mean == 0) begin
         res.status = tac_pkg::STATUS_MEAN_ZERO;
         return res;
      end
      if (mean >= FULL_READING) begin
         res.status = tac_pkg::STATUS_MEAN_FULL;
         return res;
      end
      lnr = longint'(log2_fixed(r1 * longint'(FULL_READING - mean)))
            - longint'(log2_fixed(longint'(mean)));
      lnr = (lnr * longint'(tac_pkg::LN2_Q30)) >>> 30;
      l2 = (lnr * lnr) >>> 24;
      l3 = (l2 * lnr) >>> 24;
      s = (longint'(coef_a) << 24) + longint'(coef_b) * lnr
          + longint'(coef_c) * (l3 >>> 12);
      if (s < 0) begin
         res.temp = tac_pkg::TEMP_MIN;
      end else begin
         d = s >>> 7;
         if (d == 0) begin
            res.temp = tac_pkg::TEMP_MAX;
         end else begin
            ck = (tac_pkg::CK_NUMER + longint'(unsigned'(d)) / 2)
                 / longint'(unsigned'(d));
            if (ck > tac_pkg::CK_LIMIT) res.temp = tac_pkg::TEMP_MAX;
            else res.temp = 17'(ck - longint'(tac_pkg::OFFSET_CENTI));
         end
      end
      return res;
   endfunction

   assign readings_pending = pending_readings.size();

   always @(posedge clock) begin
      int eff;
      reading_type want;
      if (reset) begin
         series_r <= tac_pkg::RESET_SERIES_RESISTANCE;
         coef_a <= tac_pkg::RESET_COEFF_A;
         coef_b <= tac_pkg::RESET_COEFF_B;
         coef_c <= tac_pkg::RESET_COEFF_C;
         avg_count <= tac_pkg::RESET_AVERAGE_COUNT;
         in_measurement <= 1'b0;
         samples_taken <= 0;
         reading_total <= 0;
         mismatch_count <= 0;
         pending_readings.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tac_pkg::REG_SERIES_RESISTANCE: series_r <= csr_data[19:0];
               tac_pkg::REG_COEFF_A:           coef_a <= csr_data[30:0];
               tac_pkg::REG_COEFF_B:           coef_b <= csr_data;
               tac_pkg::REG_COEFF_C:           coef_c <= csr_data;
               tac_pkg::REG_AVERAGE_COUNT:     avg_count <= csr_data[8:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            eff = (avg_count == 0) ? 1 : (avg_count > tac_pkg::MAX_AVERAGE_DEFAULT)
                  ? tac_pkg::MAX_AVERAGE_DEFAULT : int'(avg_count);
            if (req_command == 1'b0 || in_measurement) begin
               // a start item drops any running measurement
               int n, total;
               n = (req_command == 1'b0) ? 1 : samples_taken + 1;
               total = (req_command == 1'b0) ? int'(req_adc_sample)
                       : reading_total + int'(req_adc_sample);
               if (n >= eff) begin
                  pending_readings.push_back(mean_to_celsius(total / n));
                  in_measurement <= 1'b0;
               end else begin
                  in_measurement <= 1'b1;
               end
               samples_taken <= n;
               reading_total <= total;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_readings.size() == 0) begin
               $error("unexpected reading: temperature_centi_c %0d status %0d",
                      rsp_temperature_centi_c, rsp_status);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = pending_readings.pop_front();
               if (want.temp !== rsp_temperature_centi_c ||
                   want.status !== rsp_status) begin
                  mismatch_count <= mismatch_count + 1;
                  if (want.temp !== rsp_temperature_centi_c)
                     $error("temperature_centi_c: expected %0d actual %0d",
                            want.temp, rsp_temperature_centi_c);
                  if (want.status !== rsp_status)
                     $error("status: expected %0d actual %0d", want.status, rsp_status);
               end
            end
         end
      end
   end

endmodule

### verif/testbench.sv
// Top of the thermistor averaging core testbench: clock, reset, sample and
// register stimulus, receiver stalls and the verdict. Depends on tac_pkg, the
// core and thermistor_reading_checker.
module testbench;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 400;
   localparam int PASS_BUDGET    = 80;

   logic clock;
   logic reset;
   logic req_valid, req_stall, req_command;
   logic [tac_pkg::SAMPLE_WIDTH-1:0] req_adc_sample;
   logic rsp_valid, rsp_stall;
   logic signed [16:0] rsp_temperature_centi_c;
   logic [1:0] rsp_status;
   logic csr_valid, csr_ready;
   logic [tac_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [tac_pkg::CSR_DATA_WIDTH-1:0] csr_data;

   int mismatch_count;
   int readings_pending;
   int quiet_cycles;
   bit quiet_mode;
   bit long_hold;
   int cur_count;

   thermistor_average_to_celsius_core uut (.*);

   thermistor_reading_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stall bursts, one long hold on request
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (3000) @(posedge clock);
            long_hold = 1'b0;
         end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_sample(input logic cmd, input logic [9:0] smp);
      if (!quiet_mode && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_adc_sample <= smp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // hold the sender until every reading is back and the core is idle
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (readings_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [31:0] r1, input logic [31:0] a,
                               input logic [31:0] b, input logic [31:0] c,
                               input logic [31:0] n);
      logic [31:0] vals[5];
      vals = '{r1, a, b, c, n};
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= tac_pkg::CSR_INDEX_WIDTH'(i);
         csr_data <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      cur_count = (n[8:0] == 0) ? 1 : (n[8:0] > tac_pkg::MAX_AVERAGE_DEFAULT)
                  ? tac_pkg::MAX_AVERAGE_DEFAULT : int'(n[8:0]);
   endtask

   function automatic logic [9:0] near_reading(input int base, input int kind);
      int v;
      if (kind == 0) return 10'd0;
      if (kind == 1) return 10'd1023;
      if (kind == 2) return 10'($urandom_range(0, 1023));
      v = base + int'($urandom_range(0, 16)) - 8;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return 10'(v);
   endfunction

   // one measurement with coherent content, now and then a restart inside a short one
   task automatic send_measurement(output int sent);
      int kind, base;
      kind = $urandom_range(0, 5);
      case (kind)
         3: base = $urandom_range(1, 20);
         4: base = $urandom_range(1000, 1023);
         default: base = $urandom_range(0, 1023);
      endcase
      sent = 0;
      for (int i = 0; i < cur_count; i++) begin
         if (i > 0 && cur_count <= 16 && $urandom_range(0, 60) == 0) i = 0;
         send_sample(i != 0, near_reading(base, kind));
         sent++;
      end
   endtask

   initial begin
      int sent, budget, n;
      logic [31:0] r1, a, b, c, cnt;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= 1'b0;
      req_adc_sample <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      quiet_mode = 1'b0;
      long_hold = 1'b0;
      cur_count = 8;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle add, restart, zero mean under the reset settings
      send_sample(1'b1, 10'd300);
      send_sample(1'b0, 10'd500);
      repeat (3) send_sample(1'b1, 10'd510);
      send_sample(1'b0, 10'd0);
      repeat (7) send_sample(1'b1, 10'd0);
      drain();
      write_config(32'd10000, 32'd1109680000, 32'd261508000, 32'd909370000, 32'd1);
      send_sample(1'b0, 10'd0);
      send_sample(1'b0, 10'd1);
      send_sample(1'b0, 10'd512);
      send_sample(1'b0, 10'd1022);
      send_sample(1'b0, 10'd1023);
      send_sample(1'b1, 10'd700);
      send_sample(1'b0, 10'd341);
      drain();
      write_config(32'd10000, 32'd1109680000, 32'd261508000, 32'd909370000, 32'd2);
      send_sample(1'b0, 10'd1023);
      send_sample(1'b1, 10'd1022);
      send_sample(1'b0, 10'd0);
      send_sample(1'b1, 10'd1);
      drain();

      for (int p = 0; p < 14; p++) begin
         case (p)
            1: begin r1 = 1; a = 0; b = 32'h8000_0000; c = 32'h8000_0000; cnt = 0; end
            2: begin r1 = 1000000; a = 32'h7FFF_FFFF; b = 32'h7FFF_FFFF;
                  c = 32'h7FFF_FFFF; cnt = 511; end
            3: begin r1 = 32'hFFF0_0000; a = 32'hFFFF_FFFF; b = 0; c = 0; cnt = 256; end
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  r1 = $urandom; a = $urandom; b = $urandom; c = $urandom;
               end else begin
                  r1 = $urandom_range(1000, 100000);
                  a = 1109680000 + $urandom_range(0, 200000000) - 100000000;
                  b = 261508000 + $urandom_range(0, 100000000) - 50000000;
                  c = 909370000 + $urandom_range(0, 400000000) - 200000000;
               end
               n = $urandom_range(0, 19);
               cnt = (n == 0) ? 0 : (n == 1) ? 300 : (n < 6) ? 1 : $urandom_range(2, 6);
            end
         endcase
         if (p == 13) quiet_mode = 1'b1;
         write_config(r1, a, b, c, cnt);
         if (p == 5) long_hold = 1'b1;
         budget = 0;
         while (budget < PASS_BUDGET) begin
            if ($urandom_range(0, 9) < 8) begin
               send_measurement(sent);
               budget += sent;
            end else begin
               send_sample(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
               budget++;
            end
         end
         drain();
      end

      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
